// File: src/ufr_pkg.sv
// shared types and sizing constants for the union-find block with rollback
// no dependencies; imported by the top level
package ufr_pkg;

  // node count, checkpoint depth and undo log depth
  localparam int NODES      = 1024;
  localparam int SAVE_DEPTH = 64;
  localparam int LOG_DEPTH  = 2048;

  // node index width equals log2 of the node count, so an index needs no reduction
  localparam int NODE_W    = 10;
  localparam int SIZE_W    = $clog2(NODES + 1);
  localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int LOG_TOP_W = $clog2(LOG_DEPTH + 1);
  localparam int SAVE_AW   = (SAVE_DEPTH > 1) ? $clog2(SAVE_DEPTH) : 1;
  localparam int CP_CNT_W  = $clog2(SAVE_DEPTH + 1);
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_UNITE    = 2'd0,
    OP_FIND     = 2'd1,
    OP_SAVE     = 2'd2,
    OP_ROLLBACK = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    LOG_PARENT = 1'b0,
    LOG_SIZE   = 1'b1
  } log_kind_t;

  typedef struct packed {
    log_kind_t         kind;
    logic [NODE_W-1:0] node;
    logic [SIZE_W-1:0] value;
  } log_entry_t;

  localparam int LOG_W = $bits(log_entry_t);

endpackage

// File: src/ufr_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module ufr_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/union_find_with_rollback.sv
// union-find with rollback: save and refused ops answer straight from idle; find walks one tree
// and unite walks two, stopping there if already joined; the depth walked is at most log2 of the node count
// rollback restores the undone log entries one entry per cycle
// one item at a time: busy stays high until the result strobe; the receiver cannot stall
// reset: synchronous; a sweep then rewrites every parent and size with busy high
// depends on ufr_pkg and ufr_ram
module union_find_with_rollback
  import ufr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     opcode,
  input  logic [NODE_W-1:0]   node_a,
  input  logic [NODE_W-1:0]   node_b,
  output logic                done,
  output logic [NODE_W-1:0]   root,
  output logic                merged,
  output logic [STATUS_W-1:0] status
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_A,
    S_WALK_B,
    S_SZ_A,
    S_SZ_B,
    S_U_FIN,
    S_RB_MARK,
    S_RB_APPLY
  } state_t;

  state_t               state;
  logic [NODE_W-1:0]    clr_cnt;
  logic                 is_unite;
  logic [NODE_W-1:0]    cur;
  logic [NODE_W-1:0]    b_reg;
  logic [NODE_W-1:0]    ra;
  logic [NODE_W-1:0]    rb;
  logic [SIZE_W-1:0]    size_a;
  logic [NODE_W-1:0]    big;
  logic [SIZE_W-1:0]    big_size;
  logic                 logging;
  logic [LOG_TOP_W-1:0] mark;
  logic [LOG_TOP_W-1:0] log_top;
  logic [CP_CNT_W-1:0]  cp_count;
  status_t              status_r;

  // memory ports
  logic                 par_we;
  logic [NODE_W-1:0]    par_waddr;
  logic [NODE_W-1:0]    par_wdata;
  logic [NODE_W-1:0]    par_raddr;
  logic [NODE_W-1:0]    rd_par;
  logic                 size_we;
  logic [NODE_W-1:0]    size_waddr;
  logic [SIZE_W-1:0]    size_wdata;
  logic [NODE_W-1:0]    size_raddr;
  logic [SIZE_W-1:0]    rd_size;
  logic                 log_we;
  logic [LOG_AW-1:0]    log_waddr;
  log_entry_t           log_wdata;
  log_entry_t           rd_log;
  logic                 cp_we;
  logic [SAVE_AW-1:0]   cp_waddr;
  logic [LOG_TOP_W-1:0] cp_rdata;
  logic [SAVE_AW-1:0]   cp_raddr;

  // decode and shared compare / add unit
  logic                 accept;
  op_t                  op_in;
  logic                 cp_full;
  logic [CP_CNT_W-1:0]  cp_dec;
  logic [LOG_TOP_W-1:0] log_dec;
  logic [LOG_TOP_W:0]   log_top_p2;
  logic                 log_ok;
  logic                 at_root;
  logic                 a_bigger;
  logic [NODE_W-1:0]    small_c;
  logic [NODE_W-1:0]    big_c;
  logic [SIZE_W-1:0]    big_old;
  logic [SIZE_W-1:0]    size_sum;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign op_in   = op_t'(opcode);
  assign status  = status_r;
  assign cp_full = (cp_count == CP_CNT_W'(SAVE_DEPTH));
  assign cp_dec  = cp_count - CP_CNT_W'(1);
  assign log_dec = log_top - LOG_TOP_W'(1);

  // a unite is logged only with a checkpoint open and two free log slots
  assign log_top_p2 = {1'b0, log_top} + (LOG_TOP_W + 1)'(2);
  assign log_ok     = (cp_count != '0) && (log_top_p2 <= (LOG_TOP_W + 1)'(LOG_DEPTH));

  // parent walk: the node just read is a root when it points at itself
  assign at_root = (rd_par == cur);

  // union by size: the smaller root goes under the larger, ties put ra under rb
  assign a_bigger = (size_a > rd_size);
  assign small_c  = a_bigger ? rb : ra;
  assign big_c    = a_bigger ? ra : rb;
  assign big_old  = a_bigger ? size_a : rd_size;
  assign size_sum = size_a + rd_size;

  // read addresses
  always_comb begin
    if (state == S_IDLE) begin
      par_raddr = node_a;
    end else if (state == S_WALK_A && at_root) begin
      par_raddr = b_reg;
    end else begin
      par_raddr = rd_par;
    end
  end

  assign size_raddr = (state == S_SZ_A) ? rb : ra;
  assign cp_raddr   = cp_dec[SAVE_AW-1:0];

  // write ports, steered by the sequencer state
  always_comb begin
    par_we     = 1'b0;
    par_waddr  = '0;
    par_wdata  = '0;
    size_we    = 1'b0;
    size_waddr = '0;
    size_wdata = '0;
    log_we     = 1'b0;
    log_waddr  = log_top[LOG_AW-1:0];
    log_wdata  = '0;
    cp_we      = 1'b0;
    cp_waddr   = cp_count[SAVE_AW-1:0];
    unique case (state)
      S_CLEAR: begin
        // sweep: every node its own root of size one
        par_we     = 1'b1;
        par_waddr  = clr_cnt;
        par_wdata  = clr_cnt;
        size_we    = 1'b1;
        size_waddr = clr_cnt;
        size_wdata = SIZE_W'(1);
      end
      S_IDLE: begin
        // push the current log top on a save
        cp_we = accept && (op_in == OP_SAVE) && !cp_full;
      end
      S_SZ_B: begin
        par_we     = 1'b1;
        par_waddr  = small_c;
        par_wdata  = big_c;
        size_we    = 1'b1;
        size_waddr = big_c;
        size_wdata = size_sum;
        log_we     = log_ok;
        log_wdata  = '{kind: LOG_PARENT, node: small_c, value: SIZE_W'(small_c)};
      end
      S_U_FIN: begin
        log_we    = logging;
        log_wdata = '{kind: LOG_SIZE, node: big, value: big_size};
      end
      S_RB_APPLY: begin
        // restore the entry read in the previous cycle
        if (rd_log.kind == LOG_PARENT) begin
          par_we    = 1'b1;
          par_waddr = rd_log.node;
          par_wdata = rd_log.value[NODE_W-1:0];
        end else begin
          size_we    = 1'b1;
          size_waddr = rd_log.node;
          size_wdata = rd_log.value;
        end
      end
      default: begin
      end
    endcase
  end

  ufr_ram #(.DEPTH(NODES), .WIDTH(NODE_W)) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (rd_par)
  );

  ufr_ram #(.DEPTH(NODES), .WIDTH(SIZE_W)) u_size (
    .clk   (clk),
    .we    (size_we),
    .waddr (size_waddr),
    .wdata (size_wdata),
    .raddr (size_raddr),
    .rdata (rd_size)
  );

  ufr_ram #(.DEPTH(LOG_DEPTH), .WIDTH(LOG_W)) u_log (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .raddr (log_dec[LOG_AW-1:0]),
    .rdata (rd_log)
  );

  ufr_ram #(.DEPTH(SAVE_DEPTH), .WIDTH(LOG_TOP_W)) u_cp (
    .clk   (clk),
    .we    (cp_we),
    .waddr (cp_waddr),
    .wdata (log_top),
    .raddr (cp_raddr),
    .rdata (cp_rdata)
  );

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      log_top  <= '0;
      cp_count <= '0;
      logging  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + NODE_W'(1);
          if (clr_cnt == NODE_W'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_unite <= (op_in == OP_UNITE);
            cur      <= node_a;
            b_reg    <= node_b;
            unique case (op_in) inside
              OP_UNITE, OP_FIND: begin
                state <= S_WALK_A;
              end
              OP_SAVE: begin
                done   <= 1'b1;
                root   <= '0;
                merged <= 1'b0;
                if (cp_full) begin
                  status_r <= ST_FULL;
                end else begin
                  status_r <= ST_OK;
                  cp_count <= cp_count + CP_CNT_W'(1);
                end
              end
              default: begin
                // rollback: pop the mark, its data arrives next cycle
                if (cp_count == '0) begin
                  done     <= 1'b1;
                  root     <= '0;
                  merged   <= 1'b0;
                  status_r <= ST_EMPTY;
                end else begin
                  cp_count <= cp_dec;
                  state    <= S_RB_MARK;
                end
              end
            endcase
          end
        end
        S_WALK_A: begin
          if (at_root) begin
            if (is_unite) begin
              ra    <= cur;
              cur   <= b_reg;
              state <= S_WALK_B;
            end else begin
              done     <= 1'b1;
              root     <= cur;
              merged   <= 1'b0;
              status_r <= ST_OK;
              state    <= S_IDLE;
            end
          end else begin
            cur <= rd_par;
          end
        end
        S_WALK_B: begin
          if (at_root) begin
            rb <= cur;
            if (cur == ra) begin
              // already in one set
              done     <= 1'b1;
              root     <= cur;
              merged   <= 1'b0;
              status_r <= ST_OK;
              state    <= S_IDLE;
            end else begin
              state <= S_SZ_A;
            end
          end else begin
            cur <= rd_par;
          end
        end
        S_SZ_A: begin
          size_a <= rd_size;
          state  <= S_SZ_B;
        end
        S_SZ_B: begin
          big      <= big_c;
          big_size <= big_old;
          logging  <= log_ok;
          if (log_ok) begin
            log_top <= log_top + LOG_TOP_W'(1);
          end
          state <= S_U_FIN;
        end
        S_U_FIN: begin
          if (logging) begin
            log_top <= log_top + LOG_TOP_W'(1);
          end
          done     <= 1'b1;
          root     <= big;
          merged   <= 1'b1;
          status_r <= ST_OK;
          state    <= S_IDLE;
        end
        S_RB_MARK: begin
          mark <= cp_rdata;
          if (log_top > cp_rdata) begin
            log_top <= log_dec;
            state   <= S_RB_APPLY;
          end else begin
            done     <= 1'b1;
            root     <= '0;
            merged   <= 1'b0;
            status_r <= ST_OK;
            state    <= S_IDLE;
          end
        end
        S_RB_APPLY: begin
          // the read for the next entry overlaps the restore of this one
          if (log_top > mark) begin
            log_top <= log_dec;
          end else begin
            done     <= 1'b1;
            root     <= '0;
            merged   <= 1'b0;
            status_r <= ST_OK;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result is only shown once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // an accepted transfer either completes at once or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted transfer dropped");

  // checkpoint and log pointers stay within their stores
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (cp_count <= CP_CNT_W'(SAVE_DEPTH)) && (log_top <= LOG_TOP_W'(LOG_DEPTH)))
    else $error("checkpoint or log pointer out of range");

  // a merge is always an ok unite result
  a_merge_ok: assert property (@(posedge clk) disable iff (rst)
    (done && merged) |-> (status_r == ST_OK))
    else $error("merge flagged with error status");

endmodule

// File: tb/sv/ufr_checker.sv
`timescale 1ns / 1ps
// result checker for the union-find block with rollback: watches command and result
// transfers, keeps its own disjoint-set forest and undo log, compares every answer
// depends on ufr_pkg
module ufr_checker
  import ufr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [OP_W-1:0]     opcode,
  input  logic [NODE_W-1:0]   node_a,
  input  logic [NODE_W-1:0]   node_b,
  input  logic                done,
  input  logic [NODE_W-1:0]   root,
  input  logic                merged,
  input  logic [STATUS_W-1:0] status,
  output int                  pending,
  output int                  fails,
  output int                  merges,
  output int                  full_hits,
  output int                  empty_hits
);

  typedef struct packed {
    logic [NODE_W-1:0] root;
    logic              merged;
    status_t           status;
  } answer_t;

  logic [NODE_W-1:0] parent_of [NODES];
  logic [SIZE_W-1:0] set_size [NODES];
  log_entry_t        undo_log [LOG_DEPTH];
  int                save_marks [SAVE_DEPTH];
  int                log_top;
  int                cp_count;
  answer_t           answers_due [$];

  // walk parent links up to the root, no compression
  function automatic logic [NODE_W-1:0] root_of(logic [NODE_W-1:0] x);
    int steps;
    steps = 0;
    while (parent_of[x] != x && steps < NODES) begin
      x = parent_of[x];
      steps++;
    end
    return x;
  endfunction

  // apply one operation to the forest and return the answer it should produce
  function automatic answer_t dsu_apply(op_t op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    answer_t           ans;
    logic [NODE_W-1:0] ra, rb, t;
    log_entry_t        e;
    ans = '{root: '0, merged: 1'b0, status: ST_OK};
    case (op)
      OP_UNITE: begin
        ra = root_of(a);
        rb = root_of(b);
        if (ra == rb) begin
          ans.root = rb;
        end else begin
          // smaller set hangs under the larger, ties put a's root under b's
          if (set_size[ra] > set_size[rb]) begin
            t  = ra;
            ra = rb;
            rb = t;
          end
          if (cp_count > 0 && log_top + 2 <= LOG_DEPTH) begin
            undo_log[log_top] = '{kind: LOG_PARENT, node: ra, value: SIZE_W'(ra)};
            log_top++;
            undo_log[log_top] = '{kind: LOG_SIZE, node: rb, value: set_size[rb]};
            log_top++;
          end
          parent_of[ra] = rb;
          set_size[rb]  = set_size[rb] + set_size[ra];
          ans.root      = rb;
          ans.merged    = 1'b1;
        end
      end
      OP_FIND: ans.root = root_of(a);
      OP_SAVE: begin
        if (cp_count >= SAVE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          save_marks[cp_count] = log_top;
          cp_count++;
        end
      end
      default: begin
        if (cp_count == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          cp_count--;
          while (log_top > save_marks[cp_count]) begin
            log_top--;
            e = undo_log[log_top];
            if (e.kind == LOG_PARENT) parent_of[e.node] = e.value[NODE_W-1:0];
            else set_size[e.node] = e.value;
          end
        end
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin : monitor
    answer_t want;
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        parent_of[i] = NODE_W'(i);
        set_size[i]  = SIZE_W'(1);
      end
      log_top    = 0;
      cp_count   = 0;
      fails      = 0;
      merges     = 0;
      full_hits  = 0;
      empty_hits = 0;
      answers_due.delete();
    end else begin
      // a result at the same edge as a new command belongs to the older command
      if (done === 1'b1) begin
        if (answers_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result root=%0d merged=%0d status=%0d",
                     $realtime, root, merged, status);
        end else begin
          want = answers_due.pop_front();
          if (root !== want.root || merged !== want.merged || status !== want.status) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch exp root=%0d merged=%0d status=%0d, got %0d %0d %0d",
                       $realtime, want.root, want.merged, want.status, root, merged, status);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = dsu_apply(op_t'(opcode), node_a, node_b);
        answers_due.push_back(want);
        if (want.merged) merges++;
        if (want.status == ST_FULL) full_hits++;
        if (want.status == ST_EMPTY) empty_hits++;
      end
    end
    pending <= answers_due.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// top of the union-find with rollback testbench: clock, reset, command stimulus and verdict
// depends on ufr_pkg, union_find_with_rollback and ufr_checker
module testbench;
  import ufr_pkg::*;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     opcode;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic                done;
  logic [NODE_W-1:0]   root;
  logic                merged;
  logic [STATUS_W-1:0] status;

  int   pending, fails, merges, full_hits, empty_hits;
  int   items_sent = 0;
  bit   no_gaps = 1'b0;
  // high for the cycle after an edge at which a command transfer happened
  logic xfer_seen = 1'b0;

  union_find_with_rollback dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .opcode (opcode),
    .node_a (node_a),
    .node_b (node_b),
    .done   (done),
    .root   (root),
    .merged (merged),
    .status (status)
  );

  ufr_checker watch (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .node_a     (node_a),
    .node_b     (node_b),
    .done       (done),
    .root       (root),
    .merged     (merged),
    .status     (status),
    .pending    (pending),
    .fails      (fails),
    .merges     (merges),
    .full_hits  (full_hits),
    .empty_hits (empty_hits)
  );

  always #5 clk = ~clk;

  // sampled at the rising edge, read by the driver at the next falling edge
  always @(posedge clk) xfer_seen <= !rst && start === 1'b1 && busy === 1'b0;

  // overall time limit, far beyond the slowest legal run (reset sweep included)
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // one command: optional idle gap, then hold start until the transfer happens
  // called and returns at a falling edge; start stays high for back-to-back commands
  task automatic issue(input op_t op, input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  = 1'b1;
    opcode = op;
    node_a = a;
    node_b = b;
    do @(negedge clk); while (!xfer_seen);
    items_sent++;
  endtask

  // hold off new commands until every outstanding answer has come back
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // node near a window base, so sets grow deep instead of staying singletons
  function automatic logic [NODE_W-1:0] near(int base, int span);
    return NODE_W'(base + $urandom_range(0, span - 1));
  endfunction

  // weighted operation mix; a few nodes come from the whole index range
  task automatic random_item(input int base, input int span);
    int   r;
    op_t  op;
    logic [NODE_W-1:0] a, b;
    r = $urandom_range(0, 99);
    if (r < 40) op = OP_UNITE;
    else if (r < 75) op = OP_FIND;
    else if (r < 87) op = OP_SAVE;
    else op = OP_ROLLBACK;
    if ($urandom_range(0, 9) == 0) begin
      a = NODE_W'($urandom);
      b = NODE_W'($urandom);
    end else begin
      a = near(base, span);
      b = near(base, span);
    end
    issue(op, a, b);
  endtask

  // push checkpoints past the stack depth with logged unites in between, then
  // unwind them all and one more, so both refusals and long undo walks occur
  task automatic stack_flood(input int base);
    repeat (SAVE_DEPTH + 3) begin
      issue(OP_SAVE, NODE_W'($urandom), NODE_W'($urandom));
      if ($urandom_range(0, 2) == 0) issue(OP_UNITE, near(base, 32), near(base, 32));
    end
    repeat (SAVE_DEPTH + 4) begin
      if ($urandom_range(0, 3) == 0) issue(OP_FIND, near(base, 32), NODE_W'($urandom));
      issue(OP_ROLLBACK, NODE_W'($urandom), NODE_W'($urandom));
    end
  endtask

  initial begin
    int base, span, len;
    rst    = 1'b1;
    start  = 1'b0;
    opcode = OP_FIND;
    node_a = '0;
    node_b = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: index extremes, tie and size rules, undo and refusals
    issue(OP_FIND, 10'd0, 10'd0);
    issue(OP_FIND, 10'd1023, 10'd1023);
    issue(OP_UNITE, 10'd0, 10'd1023);       // equal sizes: 0 goes under 1023
    issue(OP_UNITE, 10'd1023, 10'd0);       // already joined, no merge
    issue(OP_UNITE, 10'd7, 10'd7);          // same node
    issue(OP_ROLLBACK, 10'h2AA, 10'h155);   // nothing open
    issue(OP_SAVE, 10'h155, 10'h2AA);
    issue(OP_UNITE, 10'h155, 10'h2AA);      // logged change
    issue(OP_UNITE, 10'h2A9, 10'h155);      // single node hangs under the pair
    issue(OP_FIND, 10'h2A9, 10'h000);
    issue(OP_UNITE, 10'h2AA, 10'h000);      // smaller pair hangs under the triple
    issue(OP_FIND, 10'h000, 10'h3FF);
    issue(OP_ROLLBACK, 10'h3FF, 10'h000);   // undoes everything since the save
    issue(OP_FIND, 10'h2A9, 10'h000);
    issue(OP_FIND, 10'h000, 10'h000);
    issue(OP_ROLLBACK, 10'h000, 10'h000);   // stack empty again
    issue(OP_SAVE, 10'h3FF, 10'h3FF);
    issue(OP_ROLLBACK, 10'h3FF, 10'h3FF);   // empty undo range
    drain();

    stack_flood($urandom_range(0, NODES - 1));
    drain();

    // random episodes, each working inside one node window
    while (items_sent < 1520) begin
      base = $urandom_range(0, NODES - 1);
      if ($urandom_range(0, 19) == 0) begin
        stack_flood(base);
      end else begin
        case ($urandom_range(0, 4))
          0:       span = 4;
          1:       span = 16;
          2:       span = 32;
          3:       span = 64;
          default: span = NODES;
        endcase
        len     = $urandom_range(20, 60);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (len) random_item(base, span);
        no_gaps = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) drain();
    end

    // let the last answers come in, then watch a while for stray strobes
    drain();
    repeat (64) @(negedge clk);

    $display("covered %0d commands: %0d unites that joined sets,", items_sent, merges);
    $display("  %0d saves refused on a full stack, %0d rollbacks with none open",
             full_hits, empty_hits);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
